// ===== rtl/mandelbrot_fixed_point_escape_assert.svh =====
// Assertion macros for the Mandelbrot escape-time block.
`ifndef MANDELBROT_FIXED_POINT_ESCAPE_ASSERT_SVH
`define MANDELBROT_FIXED_POINT_ESCAPE_ASSERT_SVH

// same-cycle implication
`define MFE_ASSERT_SAME(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
	else $error("mfe assertion failed");

// next-cycle implication
`define MFE_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
	else $error("mfe assertion failed");

`endif

// ===== rtl/mfe_pkg.sv =====
// Shared types and constants for the Mandelbrot escape-time block.
package mfe_pkg;

	localparam int MAX_DIM_DEF  = 4096;
	localparam int ITER_CAP_DEF = 4095;

	localparam int CFG_W   = 13;
	localparam int COORD_W = 12;
	localparam int CNT_W   = 12;
	localparam int SUM_W   = 36;
	localparam int ACC_W   = 37;
	localparam int NUM_W   = 34;
	localparam int Z_W     = 36;
	localparam int MAG_W   = 21;
	localparam int PROD_W  = 43;
	localparam int T_W     = 23;
	localparam int EST_W   = 24;
	localparam int REM_W   = 22;
	localparam int RSH     = 20;
	localparam int ESH     = 23;

	localparam logic [21:0] RE_SPAN   = 22'd3500000;
	localparam logic [20:0] IM_SPAN   = 21'd2000000;
	localparam logic [23:0] RECIP     = 24'd8796093;
	localparam logic [19:0] FX_ONE    = 20'd1000000;
	localparam logic [21:0] FX_TWO    = 22'd2000000;
	localparam logic [21:0] FX_THREE  = 22'd3000000;
	localparam logic [24:0] FX_FOUR   = 25'd4000000;
	localparam logic signed [Z_W-1:0] RE_OFF  = 36'sd2500000;
	localparam logic signed [Z_W-1:0] IM_OFF  = 36'sd1000000;
	localparam logic signed [Z_W-1:0] ZMAG    = 36'sd2000000;
	localparam logic [SUM_W-1:0]      SUM_MAX = {SUM_W{1'b1}};

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_LIMIT  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_INIT,
		ST_CHECK,
		ST_MUL,
		ST_EST,
		ST_REM,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic init;
		logic mul;
		logic est;
		logic rem;
		logic upd;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic at_limit;
		logic big;
		logic sum_over;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/mfe_ctrl.sv =====
// Sequencer for coordinate mapping and the escape iteration.
module mfe_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	input  mfe_pkg::dp_stat_t  stat,
	output mfe_pkg::ctrl_cmd_t cmd,
	output logic               busy
);
	import mfe_pkg::*;

	localparam int CW = $clog2(NUM_W);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          finish;

	assign finish = (state_q == ST_CHECK && (stat.at_limit || stat.big)) ||
	                (state_q == ST_UPD && stat.sum_over);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MAP) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (pixel_valid) state_d = ST_MAP;
			ST_MAP: if (cnt_q == CW'(NUM_W - 1)) state_d = ST_INIT;
			ST_INIT: state_d = ST_CHECK;
			ST_CHECK: begin
				if (finish) begin
					if (stat.out_free) state_d = ST_IDLE;
				end else state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_EST;
			ST_EST: state_d = ST_REM;
			ST_REM: state_d = ST_UPD;
			ST_UPD: begin
				if (finish) begin
					if (stat.out_free) state_d = ST_IDLE;
				end else state_d = ST_CHECK;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		busy         = (state_q != ST_IDLE);
		cmd.load     = (state_q == ST_IDLE) && pixel_valid;
		cmd.div_step = (state_q == ST_MAP);
		cmd.init     = (state_q == ST_INIT);
		cmd.mul      = (state_q == ST_MUL);
		cmd.est      = (state_q == ST_EST);
		cmd.rem      = (state_q == ST_REM);
		cmd.upd      = (state_q == ST_UPD) && !stat.sum_over;
		cmd.out_load = finish && stat.out_free;
	end

endmodule

// ===== rtl/mfe_dpath.sv =====
// Datapath: coordinate dividers, fixed-point iteration pipeline, result register.
module mfe_dpath #(
	parameter int MAX_DIM  = mfe_pkg::MAX_DIM_DEF,
	parameter int ITER_CAP = mfe_pkg::ITER_CAP_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mfe_pkg::ctrl_cmd_t           cmd,
	output mfe_pkg::dp_stat_t            stat,
	input  logic [mfe_pkg::CFG_W-1:0]    width_cfg,
	input  logic [mfe_pkg::CFG_W-1:0]    height_cfg,
	input  logic [mfe_pkg::CNT_W-1:0]    limit_cfg,
	input  logic [mfe_pkg::COORD_W-1:0]  pixel_x,
	input  logic [mfe_pkg::COORD_W-1:0]  pixel_y,
	input  logic                         last_pixel,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [mfe_pkg::CNT_W-1:0]    escape_count,
	output logic [mfe_pkg::SUM_W-1:0]    running_sum,
	output logic                         frame_done
);
	import mfe_pkg::*;

	localparam int DW = $clog2(MAX_DIM + 1);

	function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] d);
		logic [DW-1:0] r;
		if (d == '0) r = DW'(1);
		else if (32'(d) > 32'(MAX_DIM)) r = DW'(MAX_DIM);
		else r = DW'(d);
		return r;
	endfunction

	logic [NUM_W-1:0]  num_q [2];
	logic [DW-1:0]     rem_q [2];
	logic [DW-1:0]     div_q [2];
	logic [NUM_W-1:0]  num_d [2];
	logic [DW-1:0]     rem_d [2];
	logic [DW:0]       trial [2];
	logic              ge    [2];
	logic [CNT_W-1:0]  limit_q;
	logic              last_q;

	logic signed [Z_W-1:0] cre_q, cim_q, zr_q, zi_q;
	logic [CNT_W-1:0]      n_q;

	logic [MAG_W-1:0]  ar, ai;
	logic [PROD_W-1:0] p_s1   [3];
	logic              neg_s1, neg_s2, neg_s3;
	logic [PROD_W-1:0] p_s2   [3];
	logic [EST_W-1:0]  est_s2 [3];
	logic [EST_W-1:0]  est_s3 [3];
	logic [REM_W-1:0]  rem_s3 [3];
	logic [EST_W-1:0]  q      [3];
	logic [EST_W+ESH-1:0] emul [3];
	logic [PROD_W:0]   rfull  [3];
	logic [EST_W:0]    sum_sq;
	logic signed [Z_W-1:0] sr, si, pm, zr_n, zi_n;

	logic [ACC_W-1:0]  acc_q, acc_n;
	logic [SUM_W-1:0]  sat;
	logic              valid_q;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			trial[i] = {rem_q[i], num_q[i][NUM_W-1]};
			ge[i]    = trial[i] >= {1'b0, div_q[i]};
			rem_d[i] = ge[i] ? DW'(trial[i] - {1'b0, div_q[i]}) : DW'(trial[i]);
			num_d[i] = {num_q[i][NUM_W-2:0], ge[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q[0] <= NUM_W'(pixel_x) * NUM_W'(RE_SPAN);
			num_q[1] <= NUM_W'(pixel_y) * NUM_W'(IM_SPAN);
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			div_q[0] <= clamp_dim(width_cfg);
			div_q[1] <= clamp_dim(height_cfg);
			limit_q  <= (32'(limit_cfg) > 32'(ITER_CAP)) ? CNT_W'(ITER_CAP) : limit_cfg;
			last_q   <= last_pixel;
		end else if (cmd.div_step) begin
			num_q <= num_d;
			rem_q <= rem_d;
		end
	end

	assign stat.at_limit = (n_q == limit_q);
	assign stat.big = (zr_q > ZMAG) || (zr_q < -ZMAG) || (zi_q > ZMAG) || (zi_q < -ZMAG);

	assign ar = zr_q[Z_W-1] ? MAG_W'(-zr_q) : MAG_W'(zr_q);
	assign ai = zi_q[Z_W-1] ? MAG_W'(-zi_q) : MAG_W'(zi_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			p_s1[0] <= PROD_W'(ar) * PROD_W'(ar);
			p_s1[1] <= PROD_W'(ai) * PROD_W'(ai);
			p_s1[2] <= (PROD_W'(ar) * PROD_W'(ai)) << 1;
			neg_s1  <= zr_q[Z_W-1] ^ zi_q[Z_W-1];
		end
		if (cmd.est) begin
			for (int i = 0; i < 3; i++) begin
				p_s2[i]   <= p_s1[i];
				est_s2[i] <= EST_W'(emul[i] >> ESH);
			end
			neg_s2 <= neg_s1;
		end
		if (cmd.rem) begin
			for (int i = 0; i < 3; i++) begin
				est_s3[i] <= est_s2[i];
				rem_s3[i] <= REM_W'(rfull[i]);
			end
			neg_s3 <= neg_s2;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			emul[i]  = (EST_W+ESH)'(p_s1[i][PROD_W-1:RSH]) * (EST_W+ESH)'(RECIP);
			rfull[i] = (PROD_W+1)'(p_s2[i]) - (PROD_W+1)'(est_s2[i]) * (PROD_W+1)'(FX_ONE);
			q[i] = est_s3[i]
			     + EST_W'(rem_s3[i] >= REM_W'(FX_ONE))
			     + EST_W'(rem_s3[i] >= REM_W'(FX_TWO))
			     + EST_W'(rem_s3[i] >= REM_W'(FX_THREE));
		end
		sum_sq = (EST_W+1)'(q[0]) + (EST_W+1)'(q[1]);
		sr     = $signed(Z_W'(q[0]));
		si     = $signed(Z_W'(q[1]));
		pm     = neg_s3 ? -$signed(Z_W'(q[2])) : $signed(Z_W'(q[2]));
		zr_n   = sr - si + cre_q;
		zi_n   = pm + cim_q;
	end

	assign stat.sum_over = sum_sq > FX_FOUR;

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			cre_q <= $signed({{(Z_W-NUM_W){1'b0}}, num_q[0]}) - RE_OFF;
			cim_q <= $signed({{(Z_W-NUM_W){1'b0}}, num_q[1]}) - IM_OFF;
			zr_q  <= '0;
			zi_q  <= '0;
			n_q   <= '0;
		end else if (cmd.upd) begin
			zr_q <= zr_n;
			zi_q <= zi_n;
			n_q  <= n_q + 1'b1;
		end
	end

	assign acc_n = acc_q + ACC_W'(n_q);
	assign sat   = (acc_n > ACC_W'(SUM_MAX)) ? SUM_MAX : SUM_W'(acc_n);
	assign stat.out_free = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			acc_q   <= '0;
		end else begin
			if (cmd.out_load) begin
				valid_q <= 1'b1;
				acc_q   <= last_q ? '0 : ACC_W'(sat);
			end else if (valid_q && !result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			escape_count <= n_q;
			running_sum  <= sat;
			frame_done   <= last_q;
		end
	end

	assign result_valid = valid_q;

endmodule

// ===== rtl/mandelbrot_fixed_point_escape.sv =====
// Mandelbrot escape-time block: top level with configuration registers.
// Flow: a pixel is accepted in IDLE and its coordinates go through the serial dividers
// (MAP); INIT then starts the loop CHECK, MUL, EST, REM, UPD. The limit or the size test
// ends it at CHECK, the magnitude test at UPD, waiting there while the output is stalled.
// One pixel at a time; the next is taken while a result waits in the output register.
// Reset: registers to 128/128/100, frame sum cleared, no result pending.
module mandelbrot_fixed_point_escape #(
	parameter int MAX_DIM  = mfe_pkg::MAX_DIM_DEF,
	parameter int ITER_CAP = mfe_pkg::ITER_CAP_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [mfe_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        pixel_valid,
	output logic                        pixel_stall,
	input  logic [mfe_pkg::COORD_W-1:0] pixel_x,
	input  logic [mfe_pkg::COORD_W-1:0] pixel_y,
	input  logic                        last_pixel,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [mfe_pkg::CNT_W-1:0]   escape_count,
	output logic [mfe_pkg::SUM_W-1:0]   running_sum,
	output logic                        frame_done
);
	import mfe_pkg::*;

	`include "mandelbrot_fixed_point_escape_assert.svh"

	logic [CFG_W-1:0] width_q, height_q;
	logic [CNT_W-1:0] limit_q;
	ctrl_cmd_t        cmd;
	dp_stat_t         stat;
	logic             busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(128);
			height_q <= CFG_W'(128);
			limit_q  <= CNT_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				CFG_LIMIT:  limit_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	mfe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.stat        (stat),
		.cmd         (cmd),
		.busy        (busy)
	);

	mfe_dpath #(
		.MAX_DIM  (MAX_DIM),
		.ITER_CAP (ITER_CAP)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.width_cfg    (width_q),
		.height_cfg   (height_q),
		.limit_cfg    (limit_q),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.last_pixel   (last_pixel),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.escape_count (escape_count),
		.running_sum  (running_sum),
		.frame_done   (frame_done)
	);

	assign pixel_stall = busy;

	`MFE_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, pixel_valid && !pixel_stall, pixel_stall)
	`MFE_ASSERT_SAME(a_load_needs_room, clk, arst_n, cmd.out_load, stat.out_free)
	`MFE_ASSERT_SAME(a_no_update_on_escape, clk, arst_n, cmd.upd, !stat.sum_over)
	`MFE_ASSERT_NEXT(a_result_after_load, clk, arst_n, cmd.out_load, result_valid)

endmodule
